FILE: rtl/pti_pkg.sv
// Shared types, widths and helpers for the periodic table interpolator.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package pti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int ANGLE_W     = 32;
    localparam int LIDX_W      = 10;
    localparam int DATA_W      = 16;
    localparam int FRAC_W      = 15;
    localparam int POS_W       = ANGLE_W + CNT_W;
    localparam int PROD_W      = 2 * DATA_W;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    // Item after the angle multiply
    typedef struct packed {
        logic                     valid;
        logic                     func;
        logic [CNT_W-1:0]         count;
        logic [POS_W-1:0]         pos;
        logic [LIDX_W-1:0]        load_index;
        logic signed [DATA_W-1:0] load_value;
    } front_t;

    // Query after the table read
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [FRAC_W-1:0]        frac;
    } tbl_t;

    // Clamp a 17-bit signed value to the Q15 range
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/pti_front.sv
// Input capture, entry count clamp and angle-by-count multiply (two stages).
// Depends on pti_pkg.
`timescale 1ns / 1ps

module pti_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              func,
    input  logic [pti_pkg::ANGLE_W-1:0]       angle,
    input  logic [pti_pkg::LIDX_W-1:0]        load_index,
    input  logic signed [pti_pkg::DATA_W-1:0] load_value,
    input  logic [pti_pkg::CNT_W-1:0]         entry_count,
    output pti_pkg::front_t                   front
);

    logic [pti_pkg::CNT_W-1:0]         count_clamped;

    logic                              valid_a_reg;
    logic                              func_a_reg;
    logic [pti_pkg::ANGLE_W-1:0]       angle_a_reg;
    logic [pti_pkg::CNT_W-1:0]         count_a_reg;
    logic [pti_pkg::LIDX_W-1:0]        lidx_a_reg;
    logic signed [pti_pkg::DATA_W-1:0] lval_a_reg;

    logic                              valid_b_reg;
    logic                              func_b_reg;
    logic [pti_pkg::CNT_W-1:0]         count_b_reg;
    logic [pti_pkg::POS_W-1:0]         pos_b_reg;
    logic [pti_pkg::POS_W-1:0]         pos_b_next;
    logic [pti_pkg::LIDX_W-1:0]        lidx_b_reg;
    logic signed [pti_pkg::DATA_W-1:0] lval_b_reg;

    always_comb
    begin
        if (entry_count < pti_pkg::COUNT_MIN)
        begin
            count_clamped = pti_pkg::COUNT_MIN;
        end
        else if (entry_count > pti_pkg::COUNT_MAX)
        begin
            count_clamped = pti_pkg::COUNT_MAX;
        end
        else
        begin
            count_clamped = entry_count;
        end
    end

    assign pos_b_next = pti_pkg::POS_W'(angle_a_reg) * pti_pkg::POS_W'(count_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= start;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        func_a_reg  <= func;
        angle_a_reg <= angle;
        count_a_reg <= count_clamped;
        lidx_a_reg  <= load_index;
        lval_a_reg  <= load_value;

        func_b_reg  <= func_a_reg;
        count_b_reg <= count_a_reg;
        pos_b_reg   <= pos_b_next;
        lidx_b_reg  <= lidx_a_reg;
        lval_b_reg  <= lval_a_reg;
    end

    always_comb
    begin
        front.valid      = valid_b_reg;
        front.func       = func_b_reg;
        front.count      = count_b_reg;
        front.pos        = pos_b_reg;
        front.load_index = lidx_b_reg;
        front.load_value = lval_b_reg;
    end

endmodule

FILE: rtl/pti_table.sv
// Segment index and fraction split, table write for loads, dual registered read for queries.
// Depends on pti_pkg.
`timescale 1ns / 1ps

module pti_table (
    input  logic            clk,
    input  logic            rst_n,
    input  pti_pkg::front_t front,
    output pti_pkg::tbl_t   tbl
);

    logic signed [pti_pkg::DATA_W-1:0] mem [pti_pkg::TABLE_DEPTH];

    logic [pti_pkg::CNT_W-1:0]         idx_full;
    logic [pti_pkg::CNT_W-1:0]         idx;
    logic [pti_pkg::CNT_W-1:0]         next_full;
    logic [pti_pkg::CNT_W-1:0]         next;
    logic [pti_pkg::FRAC_W-1:0]        frac;
    logic                              is_query;
    logic                              wr_en;

    logic                              valid_c_reg;
    logic [pti_pkg::FRAC_W-1:0]        frac_c_reg;
    logic signed [pti_pkg::DATA_W-1:0] a_c_reg;
    logic signed [pti_pkg::DATA_W-1:0] b_c_reg;

    assign idx_full = front.pos[pti_pkg::ANGLE_W +: pti_pkg::CNT_W];

    always_comb
    begin
        if (idx_full >= front.count)
        begin
            idx  = '0;
            frac = '0;
        end
        else
        begin
            idx  = idx_full;
            frac = front.pos[pti_pkg::ANGLE_W-1 -: pti_pkg::FRAC_W];
        end
        // wrap to the first entry past the last segment
        next_full = idx + pti_pkg::CNT_W'(1);
        next      = (next_full >= front.count) ? '0 : next_full;
    end

    assign is_query = front.valid && (front.func == pti_pkg::FUNC_QUERY);
    assign wr_en    = front.valid && (front.func == pti_pkg::FUNC_LOAD)
                      && (32'(front.load_index) < 32'(pti_pkg::TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pti_pkg::IDX_W'(front.load_index)] <= front.load_value;
        end
        a_c_reg <= mem[idx[pti_pkg::IDX_W-1:0]];
        b_c_reg <= mem[next[pti_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_c_reg <= is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_c_reg <= frac;
    end

    always_comb
    begin
        tbl.valid = valid_c_reg;
        tbl.a     = a_c_reg;
        tbl.b     = b_c_reg;
        tbl.frac  = frac_c_reg;
    end

endmodule

FILE: rtl/pti_blend.sv
// Interpolation datapath: saturated difference, Q15 multiply, saturated add (three stages).
// Depends on pti_pkg.
`timescale 1ns / 1ps

module pti_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pti_pkg::tbl_t                     tbl,
    output logic                              done,
    output logic signed [pti_pkg::DATA_W-1:0] compensation
);

    logic signed [pti_pkg::DATA_W:0]   diff_wide;
    logic signed [pti_pkg::DATA_W-1:0] delta_d_next;

    logic                              valid_d_reg;
    logic signed [pti_pkg::DATA_W-1:0] a_d_reg;
    logic signed [pti_pkg::DATA_W-1:0] delta_d_reg;
    logic [pti_pkg::FRAC_W-1:0]        frac_d_reg;

    logic signed [pti_pkg::PROD_W-1:0] prod_e_next;
    logic                              valid_e_reg;
    logic signed [pti_pkg::DATA_W-1:0] a_e_reg;
    logic signed [pti_pkg::PROD_W-1:0] prod_e_reg;

    logic signed [pti_pkg::PROD_W-1:0] step_wide;
    logic signed [pti_pkg::DATA_W:0]   sum_wide;
    logic signed [pti_pkg::DATA_W-1:0] comp_next;

    logic                              done_reg;
    logic signed [pti_pkg::DATA_W-1:0] comp_reg;

    assign diff_wide    = {tbl.b[pti_pkg::DATA_W-1], tbl.b} - {tbl.a[pti_pkg::DATA_W-1], tbl.a};
    assign delta_d_next = pti_pkg::sat16(diff_wide);

    assign prod_e_next = pti_pkg::PROD_W'(delta_d_reg)
                         * pti_pkg::PROD_W'($signed({1'b0, frac_d_reg}));

    // arithmetic shift floors; the step always fits 17 bits
    assign step_wide = prod_e_reg >>> pti_pkg::FRAC_W;
    assign sum_wide  = {a_e_reg[pti_pkg::DATA_W-1], a_e_reg} + step_wide[pti_pkg::DATA_W:0];
    assign comp_next = pti_pkg::sat16(sum_wide);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_d_reg <= tbl.valid;
            valid_e_reg <= valid_d_reg;
            done_reg    <= valid_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_d_reg     <= tbl.a;
        delta_d_reg <= delta_d_next;
        frac_d_reg  <= tbl.frac;

        a_e_reg     <= a_d_reg;
        prod_e_reg  <= prod_e_next;

        comp_reg    <= comp_next;
    end

    assign done         = done_reg;
    assign compensation = comp_reg;

endmodule

FILE: rtl/periodic_table_interpolator.sv
// Top level of the periodic table interpolator: config register and pipeline hookup.
// Depends on pti_pkg, pti_front, pti_table and pti_blend.
`timescale 1ns / 1ps

// The block takes one item per clock (busy stays low) and answers each query
// once it has passed through every stage, with done high for one cycle;
// loads produce no result. The six stages are input capture, the 32x11
// angle-by-count multiply, the table read (one write and two registered reads
// of the entry memory), the saturated difference, the 16x16 Q15 multiply and
// the saturated add into the output register. The receiver cannot stall:
// take compensation in the cycle done is high. A load becomes visible to any
// query started after it. Reading an entry never loaded returns undefined
// data. Write entry_count only while no item is in flight.
module periodic_table_interpolator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic [pti_pkg::ANGLE_W-1:0]       angle,
    input  logic [pti_pkg::LIDX_W-1:0]        load_index,
    input  logic signed [pti_pkg::DATA_W-1:0] load_value,
    input  logic                              cfg_wr_en,
    input  logic [pti_pkg::CNT_W-1:0]         cfg_wr_data,
    output logic                              done,
    output logic signed [pti_pkg::DATA_W-1:0] compensation
);

    logic [pti_pkg::CNT_W-1:0] entry_count_reg;
    pti_pkg::front_t           front;
    pti_pkg::tbl_t             tbl;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= pti_pkg::COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    pti_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .angle       (angle),
        .load_index  (load_index),
        .load_value  (load_value),
        .entry_count (entry_count_reg),
        .front       (front)
    );

    pti_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .front (front),
        .tbl   (tbl)
    );

    pti_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .tbl          (tbl),
        .done         (done),
        .compensation (compensation)
    );

`ifndef SYNTHESIS
    // a query transfer yields a result
    a_query_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == pti_pkg::FUNC_QUERY)) |-> ##6 done)
        else $error("query produced no result");

    // a load transfer yields nothing
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == pti_pkg::FUNC_LOAD)) |-> ##6 !done)
        else $error("load produced a result");

    // each rising edge of done traces back to a query
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(tbl.valid, 3))
        else $error("result without a query");
`endif

endmodule
